### hw/rtl/rgb_gamma_contrast_brightness_assert.svh
// Assertion shorthands shared by the RTL.
`ifndef RGB_GAMMA_CONTRAST_BRIGHTNESS_ASSERT_SVH
`define RGB_GAMMA_CONTRAST_BRIGHTNESS_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define RGCB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check that a condition implies another one on the next edge.
`define RGCB_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

### hw/rtl/rgcb_pkg.sv
package rgcb_pkg;

  localparam int FracBits = 20;
  localparam int LogSteps = FracBits;
  localparam int ExpSteps = FracBits;
  localparam int Hundred  = 100;

  localparam logic [9:0]  EOne      = 10'd256;
  localparam logic [15:0] Recip100  = 16'd41943;
  localparam logic [30:0] TOne      = 31'h4000_0000;
  localparam logic [14:0] ValMax    = 15'd32767;

  // Register indexes on the configuration port
  typedef enum logic [1:0] {
    RegGamma    = 2'd0,
    RegContrast = 2'd1,
    RegBright   = 2'd2,
    RegDepth    = 2'd3
  } cfg_reg_e;

  localparam logic [1:0] Depth30 = 2'd0;
  localparam logic [1:0] Depth24 = 2'd1;

  typedef struct packed {
    logic [15:0] n;
    logic [23:0] lg;
  } rgcb_log_t;

  typedef logic [9:0] eq8_tab_t [256];

  function automatic logic [63:0] isqrt64(logic [63:0] x);
    logic [63:0] res;
    logic [63:0] bt;
    logic [63:0] xr;
    res = '0;
    bt  = 64'd1 << 62;
    xr  = x;
    for (int k = 0; k < 32; k++) begin
      if (xr >= res + bt) begin
        xr  = xr - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  // 2^(-2^-i) in Q1.30
  function automatic logic [30:0] exp_c(int i);
    logic [63:0] c;
    c = 64'd1 << 29;
    for (int k = 1; k <= FracBits; k++) begin
      if (k <= i) begin
        c = isqrt64(c << 30);
      end
    end
    return c[30:0];
  endfunction

  // log2(32767) in Q4.20
  function automatic logic [23:0] log_max();
    logic [63:0] m;
    logic [19:0] f;
    m = 64'(ValMax) << 16;
    f = '0;
    for (int k = 0; k < FracBits; k++) begin
      m = (m * m) >> 30;
      f = {f[18:0], 1'b0};
      if (m >= (64'd1 << 31)) begin
        m = m >> 1;
        f[0] = 1'b1;
      end
    end
    return {4'd14, f};
  endfunction

  localparam logic [23:0] LogMax = log_max();

  // Exponent 1 + gamma/100 in Q2.8, rounded
  function automatic eq8_tab_t eq8_tab();
    eq8_tab_t tab;
    int val;
    for (int g = 0; g < 256; g++) begin
      val = 256 + (g * 256 + 50) / Hundred;
      tab[g] = 10'(val);
    end
    return tab;
  endfunction

endpackage

### hw/rtl/rgcb_log.sv
module rgcb_log (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic [15:0]        n_i,
  output logic               valid_o,
  output rgcb_pkg::rgcb_log_t lg_o
);
  import rgcb_pkg::*;

  logic [LogSteps:0]   v_q;
  logic [30:0]         m_q [LogSteps+1];
  logic [FracBits-1:0] f_q [LogSteps+1];
  logic [3:0]          p_q [LogSteps+1];
  logic [15:0]         n_q [LogSteps+1];

  logic [3:0]  p0;
  logic [30:0] m0;

  // Find the leading one and normalize to Q1.30
  always_comb begin
    p0 = '0;
    for (int k = 0; k < 15; k++) begin
      if (n_i[k]) begin
        p0 = 4'(k);
      end
    end
    m0 = {n_i[14:0], 16'b0} << (4'd14 - p0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[LogSteps-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_q[0] <= m0;
      f_q[0] <= '0;
      p_q[0] <= p0;
      n_q[0] <= n_i;
    end
  end

  // One fraction bit per stage: square, then renormalize
  for (genvar s = 1; s <= LogSteps; s++) begin : g_sq
    logic [61:0] sq;
    logic [31:0] sh;
    assign sq = m_q[s-1] * m_q[s-1];
    assign sh = sq[61:30];
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        m_q[s] <= sh[31] ? sh[31:1] : sh[30:0];
        f_q[s] <= {f_q[s-1][FracBits-2:0], sh[31]};
        p_q[s] <= p_q[s-1];
        n_q[s] <= n_q[s-1];
      end
    end
  end

  assign valid_o = v_q[LogSteps];
  assign lg_o.n  = n_q[LogSteps];
  assign lg_o.lg = {p_q[LogSteps], f_q[LogSteps]};

endmodule

### hw/rtl/rgcb_exp.sv
module rgcb_exp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  rgcb_pkg::rgcb_log_t lg_i,
  input  logic [9:0]          e_i,
  output logic                valid_o,
  output logic [15:0]         g_o
);
  import rgcb_pkg::*;

  localparam int Lat = ExpSteps + 4;

  logic [Lat-1:0]      v_q;
  logic [23:0]         l_q;
  logic [15:0]         na_q;
  logic [30:0]         t_q  [ExpSteps+1];
  logic [FracBits-1:0] fp_q [ExpSteps+1];
  logic [5:0]          ip_q [ExpSteps+1];
  logic [15:0]         n_q  [ExpSteps+1];
  logic [45:0]         pm_q;
  logic [5:0]          ipm_q;
  logic [15:0]         nm_q;
  logic [15:0]         g_q;

  logic [23:0] l_d;
  logic [33:0] prod;
  logic [15:0] gam;
  logic [15:0] g_d;

  assign l_d  = (LogMax > lg_i.lg) ? LogMax - lg_i.lg : '0;
  assign prod = l_q * e_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[Lat-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      l_q     <= l_d;
      na_q    <= lg_i.n;
      t_q[0]  <= TOne;
      ip_q[0] <= prod[33:28];
      fp_q[0] <= prod[27:8];
      n_q[0]  <= na_q;
    end
  end

  // Multiply in 2^(-2^-s) for each set fraction bit, MSB first
  for (genvar s = 1; s <= ExpSteps; s++) begin : g_mul
    localparam logic [30:0] C = exp_c(s);
    logic [61:0] tp;
    assign tp = t_q[s-1] * C;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        t_q[s]  <= fp_q[s-1][FracBits-s] ? tp[60:30] : t_q[s-1];
        fp_q[s] <= fp_q[s-1];
        ip_q[s] <= ip_q[s-1];
        n_q[s]  <= n_q[s-1];
      end
    end
  end

  always_comb begin
    gam = (ipm_q >= 6'd16) ? '0 : 16'(pm_q >> (7'd30 + 7'(ipm_q)));
    if (nm_q[15]) begin
      g_d = nm_q;
    end else if (nm_q == '0) begin
      g_d = '0;
    end else if (e_i == EOne) begin
      g_d = nm_q;
    end else begin
      g_d = gam;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pm_q  <= t_q[ExpSteps] * ValMax;
      ipm_q <= ip_q[ExpSteps];
      nm_q  <= n_q[ExpSteps];
      g_q   <= g_d;
    end
  end

  assign valid_o = v_q[Lat-1];
  assign g_o     = g_q;

endmodule

### hw/rtl/rgcb_adj.sv
module rgcb_adj (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  logic [15:0] g_i,
  input  logic [7:0]  contrast_i,
  input  logic [7:0]  bright_i,
  output logic        valid_o,
  output logic [15:0] y_o
);
  import rgcb_pkg::*;

  logic [3:0]  v_q;
  logic [23:0] x_q;
  logic [23:0] x2_q;
  logic [17:0] q_q;
  logic [17:0] q3_q;
  logic        hi_q;
  logic [15:0] y_q;

  logic [39:0] xr;
  logic [24:0] q100;
  logic [23:0] rem;
  logic [18:0] c19;
  logic [15:0] cl;
  logic [8:0]  off;
  logic signed [18:0] s;
  logic [15:0] y_d;

  // Divide by 100: reciprocal estimate, then one correction
  assign xr   = x_q * Recip100;
  assign q100 = q_q * 7'd100;
  assign rem  = x2_q - q100[23:0];

  always_comb begin
    c19 = 19'(q3_q) + 19'(hi_q);
    cl  = (c19 > 19'd65535) ? 16'hFFFF : c19[15:0];
    off = {1'b0, bright_i} - 9'd100;
    s   = $signed({3'b0, cl}) + $signed({{2{off[8]}}, off, 8'b0});
    if (s < 0) begin
      y_d = '0;
    end else if (s > 19'sd65535) begin
      y_d = 16'hFFFF;
    end else begin
      y_d = s[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q  <= g_i * contrast_i;
      x2_q <= x_q;
      q_q  <= xr[39:22];
      q3_q <= q_q;
      hi_q <= rem >= 24'd100;
      y_q  <= y_d;
    end
  end

  assign valid_o = v_q[3];
  assign y_o     = y_q;

endmodule

### hw/rtl/rgb_gamma_contrast_brightness.sv
// Gamma, contrast and brightness adjust for 16-bit RGB pixels.
// Input channel: in_valid_i/in_ready_o with red_in_i, green_in_i, blue_in_i.
// Output channel: out_valid_o/out_ready_i with packed_pixel_o (30-bit
//   R:G:B at 10 bits each, or 24-bit R:G:B at 8 bits each, by output_depth).
// Config channel: cfg_valid_i/cfg_ready_o with cfg_index_i and cfg_data_i;
//   index 0 gamma, 1 contrast, 2 brightness, 3 output depth. Always ready;
//   write only while no request is in flight.
// Throughput: one request per cycle while the pipeline is not stalled. The
//   pipeline has 50 register stages: 21 stages of log2 (one squaring step
//   per fraction bit), 24 stages of exponent and 2^x (one table multiply
//   per fraction bit), 4 stages of contrast and brightness, and the output
//   register.
// Stall: the whole pipeline holds while the output register is full and the
//   receiver is not ready; in_ready_o drops in the same cycle, so nothing is
//   lost or repeated. Bubbles are not squeezed out during a stall.
// Reset: clears all valid bits and loads gamma 0, contrast 100,
//   brightness 100 and 24-bit packing. No clearing pass is needed.
`include "rgb_gamma_contrast_brightness_assert.svh"

module rgb_gamma_contrast_brightness (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] red_in_i,
  input  logic [15:0] green_in_i,
  input  logic [15:0] blue_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [29:0] packed_pixel_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i
);
  import rgcb_pkg::*;

  localparam eq8_tab_t Eq8Tab = eq8_tab();

  // Configuration registers
  logic [7:0] gamma_q;
  logic [7:0] contrast_q;
  logic [7:0] bright_q;
  logic [1:0] depth_q;
  logic [9:0] e_q;

  logic        en;
  logic        out_valid_q;
  logic [29:0] pixel_q;
  logic [29:0] pixel_d;

  logic [15:0] chan_in [3];
  logic [15:0] chan_g  [3];
  logic [15:0] chan_y  [3];
  rgcb_log_t   chan_lg [3];
  logic [2:0]  lg_v;
  logic [2:0]  g_v;
  logic [2:0]  y_v;

  // Advance the pipe whenever the output register frees up
  assign en          = !out_valid_q || out_ready_i;
  assign in_ready_o  = en;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gamma_q    <= 8'd0;
      contrast_q <= 8'd100;
      bright_q   <= 8'd100;
      depth_q    <= Depth24;
      e_q        <= EOne;
    end else begin
      e_q <= Eq8Tab[gamma_q];
      if (cfg_valid_i) begin
        case (cfg_reg_e'(cfg_index_i))
          RegGamma:    gamma_q    <= cfg_data_i;
          RegContrast: contrast_q <= cfg_data_i;
          RegBright:   bright_q   <= cfg_data_i;
          RegDepth:    depth_q    <= cfg_data_i[1:0];
          default: ;
        endcase
      end
    end
  end

  assign chan_in[0] = red_in_i;
  assign chan_in[1] = green_in_i;
  assign chan_in[2] = blue_in_i;

  // Three identical channel pipes, stepping in lockstep
  for (genvar c = 0; c < 3; c++) begin : g_chan
    rgcb_log u_log (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (in_valid_i),
      .n_i     (chan_in[c]),
      .valid_o (lg_v[c]),
      .lg_o    (chan_lg[c])
    );

    rgcb_exp u_exp (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (lg_v[c]),
      .lg_i    (chan_lg[c]),
      .e_i     (e_q),
      .valid_o (g_v[c]),
      .g_o     (chan_g[c])
    );

    rgcb_adj u_adj (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .en_i       (en),
      .valid_i    (g_v[c]),
      .g_i        (chan_g[c]),
      .contrast_i (contrast_q),
      .bright_i   (bright_q),
      .valid_o    (y_v[c]),
      .y_o        (chan_y[c])
    );
  end

  // Pack the top bits of each channel; unused depth codes give zero
  always_comb begin
    case (depth_q)
      Depth30: pixel_d = {chan_y[0][15:6], chan_y[1][15:6], chan_y[2][15:6]};
      Depth24: pixel_d = {6'b0, chan_y[0][15:8], chan_y[1][15:8], chan_y[2][15:8]};
      default: pixel_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= y_v[0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pixel_q <= pixel_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign packed_pixel_o = pixel_q;

  `RGCB_ASSERT(a_chan_lockstep, (y_v == {3{y_v[0]}}) && (lg_v == {3{lg_v[0]}}), "channel skew")
  `RGCB_ASSERT_NEXT(a_stall_holds, !en, out_valid_q, "stalled result dropped")
  `RGCB_ASSERT_NEXT(a_exp_tracks, 1'b1, e_q == Eq8Tab[$past(gamma_q)], "gamma exponent stale")

endmodule
